FILE: hw/rtl/ltm_pkg.sv
package ltm_pkg;

    localparam int ZOOM_W = 5;
    localparam int TILE_W = 20;
    localparam int COL_W = 30;
    localparam int T_W = 41;
    localparam int D_W = 48;
    localparam int DF = 44;
    localparam int ANG_W = 60;
    localparam int ZX = 20;
    localparam int NR_CELLS = 46;
    localparam int NH_CELLS = 48;
    localparam int DEF_MAX_ZOOM = 20;
    localparam int DEF_ANGLE_FRAC_BITS = 23;
    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 5'd12;
    localparam real PI_R = 3.14159265358979323846;
    localparam real DEG_PER_RAD = 180.0 / PI_R;
    localparam real INV_PI = 1.0 / PI_R;
    localparam real INV_2PI = 0.5 / PI_R;

    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
    } in_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile_column;
        logic [TILE_W-1:0] tile_row;
        logic              clamped;
    } out_t;

    typedef struct packed {
        logic                    valid;
        logic                    lat_neg;
        logic                    lat_big;
        logic                    col_lo;
        logic                    col_hi;
        logic [ZOOM_W-1:0]       zoom;
        logic [COL_W-1:0]        col;
        logic [T_W-1:0]          t;
        logic signed [D_W-1:0]   x;
        logic signed [D_W-1:0]   y;
        logic signed [ANG_W-1:0] z;
    } pipe_t;

    // Rotation angle of one circular step, in degrees with zf fraction bits.
    function automatic logic signed [ANG_W-1:0] atan_deg(input int i, input int zf);
        real r;
        r = $atan(2.0 ** (-i)) * DEG_PER_RAD;
        return ANG_W'(longint'(r * (2.0 ** zf)));
    endfunction

    // Hyperbolic step angle, scaled by 1/pi so the sum is psi/(2*pi).
    function automatic logic signed [ANG_W-1:0] atanh_sc(input int s);
        real r;
        r = $atanh(2.0 ** (-s)) * INV_PI;
        return ANG_W'(longint'(r * (2.0 ** DF)));
    endfunction

    function automatic logic signed [ANG_W-1:0] ln2_sc(input int e);
        real r;
        r = real'(e) * $ln(2.0) * INV_2PI;
        return ANG_W'(longint'(r * (2.0 ** DF)));
    endfunction

    function automatic logic signed [D_W-1:0] inv_gain(input int nr);
        real g;
        g = 1.0;
        for (int i = 0; i < nr; i++) begin
            g = g * $pow(1.0 + 2.0 ** (-2 * i), -0.5);
        end
        return D_W'(longint'(g * (2.0 ** DF)));
    endfunction

    // Shift of the k-th hyperbolic step; steps 4, 13, 40 are run twice.
    function automatic int hyp_shift(input int k);
        int s;
        int rep;
        bit done;
        s = 1;
        rep = 4;
        done = 1'b0;
        for (int j = 0; j < k; j++) begin
            if (s == rep && !done) begin
                done = 1'b1;
            end else begin
                if (s == rep) begin
                    rep = 3 * rep + 1;
                    done = 1'b0;
                end
                s = s + 1;
            end
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/ltm_div_cell.sv
module ltm_div_cell
    import ltm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  pipe_t d_in,
    output pipe_t d_out
);

    localparam logic [T_W-1:0] DIVISOR = T_W'(360) << ANGLE_FRAC_BITS;

    pipe_t q_reg, q_next;
    logic [T_W-1:0] t2;
    logic bit_out;

    always_comb begin
        q_next = d_in;
        t2 = {d_in.t[T_W-2:0], 1'b0};
        bit_out = (t2 >= DIVISOR);
        q_next.t = bit_out ? (t2 - DIVISOR) : t2;
        q_next.col = {d_in.col[COL_W-2:0], bit_out};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule

FILE: hw/rtl/ltm_rot_cell.sv
module ltm_rot_cell
    import ltm_pkg::*;
#(
    parameter int SHIFT = 0,
    parameter logic signed [ANG_W-1:0] STEP = '0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  pipe_t d_in,
    output pipe_t d_out
);

    pipe_t q_reg, q_next;

    always_comb begin
        q_next = d_in;
        if (!d_in.z[ANG_W-1]) begin
            q_next.x = d_in.x - (d_in.y >>> SHIFT);
            q_next.y = d_in.y + (d_in.x >>> SHIFT);
            q_next.z = d_in.z - STEP;
        end else begin
            q_next.x = d_in.x + (d_in.y >>> SHIFT);
            q_next.y = d_in.y - (d_in.x >>> SHIFT);
            q_next.z = d_in.z + STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule

FILE: hw/rtl/ltm_hyp_cell.sv
module ltm_hyp_cell
    import ltm_pkg::*;
#(
    parameter int SHIFT = 1,
    parameter logic signed [ANG_W-1:0] STEP = '0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  pipe_t d_in,
    output pipe_t d_out
);

    pipe_t q_reg, q_next;

    // Vectoring mode: y is driven to zero and z collects atanh(y/x).
    always_comb begin
        q_next = d_in;
        if (!d_in.y[D_W-1]) begin
            q_next.x = d_in.x - (d_in.y >>> SHIFT);
            q_next.y = d_in.y - (d_in.x >>> SHIFT);
            q_next.z = d_in.z + STEP;
        end else begin
            q_next.x = d_in.x + (d_in.y >>> SHIFT);
            q_next.y = d_in.y + (d_in.x >>> SHIFT);
            q_next.z = d_in.z - STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule

FILE: hw/rtl/latlon_to_map_tile_index.sv
// Map tile index unit: latitude/longitude in fixed-point degrees in, Web
// Mercator tile column and row at the configured zoom out.
// Input words arrive on s_valid/s_ready/s_data, result words leave on
// m_valid/m_ready/m_data; one result word per input word, in order.
// The zoom register is written with zoom_wr_en/zoom_wr_data; the user must
// write it only while idle, as the block itself does not enforce this. Throughput
// is one word per cycle while the receiver does not stall. The chain is
// one input stage, MAX_ZOOM long-division cells for the column, 46
// circular rotation cells for sine and cosine, one normalize stage, 48
// hyperbolic vectoring cells for the log, and one output stage.
// The whole chain advances together; when the receiver holds m_ready low
// with a word waiting, every cell holds and s_ready drops in the same
// cycle, so nothing is lost. Reset empties the chain and sets zoom to 12.
// Latitudes at or beyond 86 degrees and longitudes outside the grid give
// an edge tile with clamped set.
module latlon_to_map_tile_index
    import ltm_pkg::*;
#(
    parameter int MAX_ZOOM = DEF_MAX_ZOOM,
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              zoom_wr_en,
    input  logic [ZOOM_W-1:0] zoom_wr_data
);

    localparam int ROT0 = MAX_ZOOM;
    localparam int NORM = ROT0 + NR_CELLS;
    localparam int HYP0 = NORM + 1;
    localparam int LAST = HYP0 + NH_CELLS;
    localparam int ZF = ANGLE_FRAC_BITS + ZX;
    localparam logic signed [39:0] LON_OFF = 40'(180) << ANGLE_FRAC_BITS;
    localparam logic signed [39:0] LON_FULL = 40'(360) << ANGLE_FRAC_BITS;
    localparam logic signed [39:0] LAT_LIM = 40'(86) << ANGLE_FRAC_BITS;
    localparam logic signed [D_W-1:0] D_ONE = D_W'(1) << DF;
    localparam logic signed [ANG_W-1:0] Z_ONE = ANG_W'(1) << DF;
    localparam logic signed [ANG_W-1:0] Z_HALF = ANG_W'(1) << (DF - 1);
    localparam logic [ZOOM_W-1:0] ZMAX = ZOOM_W'(MAX_ZOOM);

    logic [ZOOM_W-1:0] zoom_level_reg;
    logic              en;
    pipe_t             pipe [0:LAST];
    pipe_t             in_next, norm_next;
    logic signed [39:0] lat_ext, alat, v;
    logic signed [D_W-1:0] a_val, b_val, b_sh;
    logic signed [ANG_W-1:0] e_const, y_fix;
    logic              m_valid_reg;
    out_t              m_data_reg, m_data_next;
    logic [ZOOM_W-1:0] m_zoom_reg;
    logic [COL_W:0]    n_minus1;
    logic [COL_W-1:0]  col_sh;
    logic [DF-1:0]     row_sh;

    assign en = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_level_reg <= ZOOM_RESET;
        end else if (zoom_wr_en) begin
            zoom_level_reg <= zoom_wr_data;
        end
    end

    always_comb begin
        lat_ext = 40'(s_data.latitude);
        alat = lat_ext[39] ? -lat_ext : lat_ext;
        v = 40'(s_data.longitude) + LON_OFF;
        in_next = '0;
        in_next.valid = s_valid;
        in_next.lat_neg = lat_ext[39];
        in_next.lat_big = (alat >= LAT_LIM);
        in_next.col_lo = v[39];
        in_next.col_hi = !v[39] && (v >= LON_FULL);
        in_next.zoom = (zoom_level_reg > ZMAX) ? ZMAX : zoom_level_reg;
        in_next.t = T_W'(v);
        in_next.x = inv_gain(NR_CELLS);
        in_next.y = '0;
        in_next.z = ANG_W'(alat) << ZX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe[0].valid <= 1'b0;
        end else if (en) begin
            pipe[0] <= in_next;
        end
    end

    for (genvar k = 0; k < MAX_ZOOM; k++) begin : g_div
        ltm_div_cell #(
            .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .d_in(pipe[k]), .d_out(pipe[k+1])
        );
    end

    for (genvar k = 0; k < NR_CELLS; k++) begin : g_rot
        ltm_rot_cell #(
            .SHIFT(k),
            .STEP(atan_deg(k, ZF))
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .d_in(pipe[ROT0+k]), .d_out(pipe[ROT0+k+1])
        );
    end

    // x holds cos and y holds sin. ln((1+sin)/cos) is split into a power of
    // two on cos and a ratio near one for the hyperbolic cells.
    always_comb begin
        norm_next = pipe[NORM];
        a_val = D_ONE + (pipe[NORM].y[D_W-1] ? '0 : pipe[NORM].y);
        b_val = (pipe[NORM].x <= 0) ? D_W'(1) : pipe[NORM].x;
        if (b_val >= D_ONE) begin
            b_sh = b_val;
            e_const = ln2_sc(0);
        end else if (b_val >= (D_ONE >>> 1)) begin
            b_sh = b_val <<< 1;
            e_const = ln2_sc(1);
        end else if (b_val >= (D_ONE >>> 2)) begin
            b_sh = b_val <<< 2;
            e_const = ln2_sc(2);
        end else if (b_val >= (D_ONE >>> 3)) begin
            b_sh = b_val <<< 3;
            e_const = ln2_sc(3);
        end else begin
            b_sh = b_val <<< 4;
            e_const = ln2_sc(4);
        end
        norm_next.x = a_val + b_sh;
        norm_next.y = a_val - b_sh;
        norm_next.z = e_const;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe[HYP0].valid <= 1'b0;
        end else if (en) begin
            pipe[HYP0] <= norm_next;
        end
    end

    for (genvar k = 0; k < NH_CELLS; k++) begin : g_hyp
        ltm_hyp_cell #(
            .SHIFT(hyp_shift(k)),
            .STEP(atanh_sc(hyp_shift(k)))
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .d_in(pipe[HYP0+k]), .d_out(pipe[HYP0+k+1])
        );
    end

    always_comb begin
        n_minus1 = ((COL_W+1)'(1) << pipe[LAST].zoom) - (COL_W+1)'(1);
        col_sh = pipe[LAST].col >> (ZMAX - pipe[LAST].zoom);
        y_fix = pipe[LAST].lat_neg ? (Z_HALF + pipe[LAST].z) : (Z_HALF - pipe[LAST].z);
        row_sh = y_fix[DF-1:0] >> (7'(DF) - 7'(pipe[LAST].zoom));
        m_data_next.clamped = 1'b0;
        if (pipe[LAST].col_lo) begin
            m_data_next.tile_column = '0;
            m_data_next.clamped = 1'b1;
        end else if (pipe[LAST].col_hi) begin
            m_data_next.tile_column = TILE_W'(n_minus1);
            m_data_next.clamped = 1'b1;
        end else begin
            m_data_next.tile_column = TILE_W'(col_sh);
        end
        if (pipe[LAST].lat_big) begin
            m_data_next.tile_row = pipe[LAST].lat_neg ? TILE_W'(n_minus1) : '0;
            m_data_next.clamped = 1'b1;
        end else if (y_fix[ANG_W-1]) begin
            m_data_next.tile_row = '0;
            m_data_next.clamped = 1'b1;
        end else if (y_fix >= Z_ONE) begin
            m_data_next.tile_row = TILE_W'(n_minus1);
            m_data_next.clamped = 1'b1;
        end else begin
            m_data_next.tile_row = TILE_W'(row_sh);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= pipe[LAST].valid;
            m_data_reg <= m_data_next;
            m_zoom_reg <= pipe[LAST].zoom;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // An unclamped word lies inside the grid of its own zoom.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.clamped |->
            ((m_data.tile_row >> m_zoom_reg) == 0) &&
            ((m_data.tile_column >> m_zoom_reg) == 0))
        else $error("unclamped tile index outside the grid");

    // A stalled chain holds the word at its tail.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(pipe[LAST].valid))
        else $error("pipeline tail moved during a stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_zoom_reg))
        else $error("result word dropped while the receiver stalled");

endmodule

FILE: test/latlon_to_map_tile_index_test.sv
module latlon_to_map_tile_index_test
    import ltm_pkg::*;
();

    localparam logic [63:0] Q_ONE = 64'd1 << 60;
    localparam longint DEG = longint'(1) << 23;
    localparam int ZOOM_CAP = 20;
    localparam int MAX_LAT_WAIT = 150;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic zoom_wr_en = 1'b0;
    logic [ZOOM_W-1:0] zoom_wr_data = '0;

    in_t pending_words[$];
    out_t expected_tiles[$];
    logic [4:0] model_zoom = ZOOM_RESET;
    logic [63:0] pi_q60;
    logic [63:0] ln2_q60;
    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    bit in_fire = 1'b0;

    latlon_to_map_tile_index dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .zoom_wr_en(zoom_wr_en), .zoom_wr_data(zoom_wr_data)
    );

    always #2 aclk = ~aclk;

    // Low 64 bits of (a*b) >> sh, with a full 128-bit product.
    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        return p[63:0];
    endfunction

    function automatic logic [63:0] div_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] q;
        if (b == 0) begin
            return 64'd0;
        end
        q = {4'd0, a, 60'd0} / {64'd0, b};
        return q[63:0];
    endfunction

    function automatic logic [63:0] atan_recip(input logic [63:0] k);
        logic [63:0] p;
        logic [63:0] sum;
        p = Q_ONE / k;
        sum = 0;
        for (int j = 0; p != 0 && j < 64; j++) begin
            if (j & 1) begin
                sum = sum - p / (2 * j + 1);
            end else begin
                sum = sum + p / (2 * j + 1);
            end
            p = p / (k * k);
        end
        return sum;
    endfunction

    function automatic longint ln_q60(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] sum;
        longint e;
        x = xin;
        e = 0;
        sum = 0;
        if (x < (Q_ONE >> 6)) begin
            x = Q_ONE >> 6;
        end
        while (x >= 2 * Q_ONE) begin
            x = x >> 1;
            e++;
        end
        while (x < Q_ONE) begin
            x = x << 1;
            e--;
        end
        t = div_q60(x - Q_ONE, x + Q_ONE);
        t2 = mul_shr(t, t, 60);
        p = t;
        for (int k = 0; p != 0 && k < 64; k++) begin
            sum = sum + p / (2 * k + 1);
            p = mul_shr(p, t2, 60);
        end
        return longint'(2 * sum) + e * longint'(ln2_q60);
    endfunction

    function automatic out_t tile_of(input in_t w, input logic [4:0] zreg);
        int z;
        longint lat;
        longint v;
        longint full;
        longint s;
        longint c;
        longint psi;
        longint y;
        logic [63:0] n;
        logic [63:0] col;
        logic [63:0] row;
        logic [63:0] t;
        logic [63:0] alat;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ut;
        bit clamp;
        out_t r;
        z = (zreg > ZOOM_CAP) ? ZOOM_CAP : int'(zreg);
        n = 64'd1 << z;
        lat = longint'(w.latitude);
        v = longint'(w.longitude) + 180 * DEG;
        full = 360 * DEG;
        col = 0;
        row = 0;
        clamp = 1'b0;
        s = 0;
        c = 0;
        if (v < 0) begin
            clamp = 1'b1;
        end else if (v >= full) begin
            col = n - 1;
            clamp = 1'b1;
        end else begin
            ut = v;
            for (int i = 0; i < z; i++) begin
                ut = ut << 1;
                col = col << 1;
                if (ut >= full) begin
                    ut = ut - full;
                    col = col | 1;
                end
            end
        end
        alat = (lat < 0) ? -lat : lat;
        if (alat >= 86 * DEG) begin
            row = (lat < 0) ? n - 1 : 0;
            clamp = 1'b1;
        end else begin
            x = mul_shr(alat << 33, pi_q60 / 180, 56);
            x2 = mul_shr(x, x, 60);
            t = x;
            for (int k = 1; t != 0 && k < 64; k++) begin
                s = (k & 1) ? s + longint'(t) : s - longint'(t);
                t = mul_shr(t, x2, 60) / ((2 * k) * (2 * k + 1));
            end
            t = Q_ONE;
            for (int k = 1; t != 0 && k < 64; k++) begin
                c = (k & 1) ? c + longint'(t) : c - longint'(t);
                t = mul_shr(t, x2, 60) / ((2 * k - 1) * (2 * k));
            end
            if (s < 0) begin
                s = 0;
            end
            if (c <= 0) begin
                c = 1;
            end
            psi = ln_q60(Q_ONE + s) - ln_q60(c);
            if (lat < 0) begin
                psi = -psi;
            end
            if (psi >= 0) begin
                y = longint'(Q_ONE / 2) - longint'(div_q60(psi, 2 * pi_q60));
            end else begin
                y = longint'(Q_ONE / 2) + longint'(div_q60(-psi, 2 * pi_q60));
            end
            if (y < 0) begin
                clamp = 1'b1;
            end else if (y >= longint'(Q_ONE)) begin
                row = n - 1;
                clamp = 1'b1;
            end else begin
                row = y >> (60 - z);
            end
        end
        r.tile_column = col[TILE_W-1:0];
        r.tile_row = row[TILE_W-1:0];
        r.clamped = clamp;
        return r;
    endfunction

    // Input side: predict at acceptance, track register writes.
    always @(posedge aclk) begin
        in_fire = s_valid && s_ready;
        if (in_fire) begin
            expected_tiles.push_back(tile_of(s_data, model_zoom));
        end
        if (zoom_wr_en) begin
            model_zoom = zoom_wr_data;
        end
    end

    always @(negedge aclk) begin
        if (!s_valid || in_fire) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
                s_valid <= 1'b1;
                s_data <= pending_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        out_t want;
        if (m_valid && m_ready) begin
            if (expected_tiles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: col %0d row %0d clamped %0d",
                             m_data.tile_column, m_data.tile_row, m_data.clamped);
                end
            end else begin
                want = expected_tiles.pop_front();
                if (want.tile_column !== m_data.tile_column || want.tile_row !== m_data.tile_row
                        || want.clamped !== m_data.clamped) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected col %0d row %0d clamped %0d, got %0d %0d %0d",
                                 want.tile_column, want.tile_row, want.clamped,
                                 m_data.tile_column, m_data.tile_row, m_data.clamped);
                    end
                end
            end
        end
    end

    task automatic add_pos(input longint lat, input longint lon);
        in_t w;
        w.latitude = lat[30:0];
        w.longitude = lon[31:0];
        pending_words.push_back(w);
    endtask

    task automatic add_random_pos();
        longint lat;
        longint lon;
        if ($urandom_range(9) == 0) begin
            lat = longint'($urandom());
        end else if ($urandom_range(9) == 0) begin
            lat = longint'($urandom_range(0, 2 * 90 * 8388608)) - 90 * DEG;
        end else begin
            lat = longint'($urandom_range(0, 1509949440)) - 754974720;
        end
        if ($urandom_range(9) == 0) begin
            lon = longint'($urandom());
        end else begin
            lon = longint'($urandom_range(0, 32'd3019898880)) - 1509949440;
        end
        add_pos(lat, lon);
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || s_valid || expected_tiles.size() > 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_zoom(input logic [ZOOM_W-1:0] value);
        @(negedge aclk);
        zoom_wr_en <= 1'b1;
        zoom_wr_data <= value;
        @(negedge aclk);
        zoom_wr_en <= 1'b0;
    endtask

    initial begin
        logic [ZOOM_W-1:0] zooms[6];
        pi_q60 = 16 * atan_recip(5) - 4 * atan_recip(239);
        begin
            logic [63:0] p;
            logic [63:0] sum;
            p = Q_ONE / 3;
            sum = 0;
            for (int k = 0; p != 0 && k < 64; k++) begin
                sum = sum + p / (2 * k + 1);
                p = p / 9;
            end
            ln2_q60 = 2 * sum;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset zoom: grid edges, the Mercator cutoff,
        // the 86 degree limit, the poles and the raw field extremes.
        add_pos(0, 0);
        add_pos(0, -180 * DEG);
        add_pos(0, -180 * DEG - 1);
        add_pos(0, 180 * DEG);
        add_pos(0, 180 * DEG - 1);
        add_pos(0, 1509949440);
        add_pos(0, -1509949440);
        add_pos(0, 32'h7FFFFFFF);
        add_pos(0, -(longint'(1) << 31));
        add_pos(713361408, 12345);
        add_pos(-713361408, -12345);
        add_pos(713445294, 0);
        add_pos(-713445294, 0);
        add_pos(86 * DEG, 0);
        add_pos(-86 * DEG, 0);
        add_pos(86 * DEG - 1, 0);
        add_pos(-86 * DEG + 1, 0);
        add_pos(90 * DEG, 0);
        add_pos(-90 * DEG, 0);
        add_pos(754974720, 1509949440);
        add_pos(-754974720, -1509949440);
        add_pos(1073741823, 32'h7FFFFFFF);
        add_pos(-1073741824, -(longint'(1) << 31));
        add_pos(1, -1);
        add_pos(-1, 1);
        send_idle = 26;
        recv_idle = 81;
        wait_idle();

        zooms[0] = 5'd0;
        zooms[1] = 5'd20;
        zooms[2] = 5'd31;
        zooms[3] = 5'd12;
        zooms[4] = 5'($urandom_range(1, 19));
        zooms[5] = 5'($urandom_range(0, 31));
        for (int ph = 0; ph < 6; ph++) begin
            write_zoom(zooms[ph]);
            send_idle = (ph < 2) ? 26 : (ph < 4) ? 81 : 0;
            recv_idle = (ph < 2) ? 81 : (ph < 4) ? 26 : 0;
            for (int i = 0; i < 240; i++) begin
                add_random_pos();
            end
            wait_idle();
        end

        repeat (MAX_LAT_WAIT) @(negedge aclk);
        if (mismatches == 0 && expected_tiles.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ltm_pkg.sv
hw/rtl/ltm_div_cell.sv
hw/rtl/ltm_rot_cell.sv
hw/rtl/ltm_hyp_cell.sv
hw/rtl/latlon_to_map_tile_index.sv
test/latlon_to_map_tile_index_test.sv
